### src/kect_pkg.sv
package kect_pkg;

	localparam int KEY_W          = 50;
	localparam int AMT_W          = 48;
	localparam int COUNT_W        = 32;
	localparam int ROW_OUT_W      = 6;
	localparam int ROWS_OUT_W     = 7;
	localparam int TABLE_ROWS_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AMT_W-1:0] amount;
	} item_t;

endpackage

### src/kect_front.sv
module kect_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            enable,
	input  logic            start,
	input  kect_pkg::item_t item,
	output logic            busy,
	output logic            q_vld,
	output kect_pkg::item_t q_item,
	input  logic            q_take
);

	localparam int DEPTH = kect_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	kect_pkg::item_t      queue_q [DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 push;

	assign busy   = (fill_q == FILL_W'(DEPTH));
	assign q_vld  = (fill_q != '0);
	assign q_item = queue_q[rd_q];
	// disabled words are taken and dropped here
	assign push   = start && !busy && enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_take) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !q_take) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_take) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= item;
		end
	end

endmodule

### src/kect_back.sv
module kect_back #(
	parameter int TABLE_ROWS = kect_pkg::TABLE_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_vld,
	input  kect_pkg::item_t                      q_item,
	output logic                                 q_take,
	output logic                                 done,
	output logic [kect_pkg::ROW_OUT_W-1:0]       row_index,
	output logic                                 was_inserted,
	output logic                                 was_dropped,
	output logic [kect_pkg::COUNT_W-1:0]         count_after,
	output logic [kect_pkg::AMT_W-1:0]           total_after,
	output logic [kect_pkg::ROWS_OUT_W-1:0]      rows_in_use,
	output logic [kect_pkg::COUNT_W-1:0]         drop_count
);

	localparam int IDX_W = $clog2(TABLE_ROWS);
	localparam int OCC_W = $clog2(TABLE_ROWS + 1);
	localparam int KEY_W = kect_pkg::KEY_W;
	localparam int AMT_W = kect_pkg::AMT_W;
	localparam int CNT_W = kect_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	logic [KEY_W-1:0] key_mem [TABLE_ROWS];
	logic [CNT_W-1:0] cnt_mem [TABLE_ROWS];
	logic [AMT_W-1:0] tot_mem [TABLE_ROWS];

	state_t           state_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] scan_q;
	logic [CNT_W-1:0] drop_q;
	logic             cmp_vld_q;
	logic             done_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic [KEY_W-1:0] key_q;
	logic [AMT_W-1:0] amt_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic [AMT_W-1:0] tot_rd_q;

	logic             hit;
	logic             more;
	logic             miss_end;
	logic             room;
	logic [OCC_W-1:0] occ_inc;
	logic [CNT_W-1:0] drop_next;
	logic [CNT_W-1:0] cnt_new;
	logic [AMT_W:0]   tot_sum;
	logic [AMT_W-1:0] tot_new;

	assign q_take    = (state_q == ST_IDLE) && q_vld;
	// read data comes back in the cycle after its address
	assign hit       = (state_q == ST_SCAN) && cmp_vld_q && (key_rd_q == key_q);
	assign more      = (scan_q < occ_q);
	assign miss_end  = (state_q == ST_SCAN) && !hit && !more && !cmp_vld_q;
	assign room      = (occ_q < OCC_W'(TABLE_ROWS));
	assign occ_inc   = occ_q + 1'b1;
	assign drop_next = (drop_q == '1) ? drop_q : drop_q + 1'b1;
	assign cnt_new   = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
	assign tot_sum   = {1'b0, tot_rd_q} + {1'b0, amt_q};
	assign tot_new   = tot_sum[AMT_W] ? '1 : tot_sum[AMT_W-1:0];
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			occ_q     <= '0;
			scan_q    <= '0;
			drop_q    <= '0;
			cmp_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_vld) begin
						state_q   <= ST_SCAN;
						scan_q    <= '0;
						cmp_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q   <= ST_UPD;
						cmp_vld_q <= 1'b0;
					end else if (more) begin
						scan_q    <= scan_q + 1'b1;
						cmp_vld_q <= 1'b1;
					end else if (cmp_vld_q) begin
						cmp_vld_q <= 1'b0;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (room) begin
							occ_q <= occ_inc;
						end else begin
							drop_q <= drop_next;
						end
					end
				end
				ST_UPD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			key_q <= q_item.key;
			amt_q <= q_item.amount;
		end
		if ((state_q == ST_SCAN) && !hit && more) begin
			cmp_idx_q <= scan_q[IDX_W-1:0];
		end
		key_rd_q <= key_mem[scan_q[IDX_W-1:0]];
		cnt_rd_q <= cnt_mem[cmp_idx_q];
		tot_rd_q <= tot_mem[cmp_idx_q];

		if (miss_end && room) begin
			key_mem[occ_q[IDX_W-1:0]] <= key_q;
			cnt_mem[occ_q[IDX_W-1:0]] <= CNT_W'(1);
			tot_mem[occ_q[IDX_W-1:0]] <= amt_q;
			row_index    <= kect_pkg::ROW_OUT_W'(occ_q);
			was_inserted <= 1'b1;
			was_dropped  <= 1'b0;
			count_after  <= CNT_W'(1);
			total_after  <= amt_q;
			rows_in_use  <= kect_pkg::ROWS_OUT_W'(occ_inc);
			drop_count   <= drop_q;
		end else if (miss_end) begin
			row_index    <= '0;
			was_inserted <= 1'b0;
			was_dropped  <= 1'b1;
			count_after  <= '0;
			total_after  <= '0;
			rows_in_use  <= kect_pkg::ROWS_OUT_W'(occ_q);
			drop_count   <= drop_next;
		end else if (state_q == ST_UPD) begin
			cnt_mem[cmp_idx_q] <= cnt_new;
			tot_mem[cmp_idx_q] <= tot_new;
			row_index    <= kect_pkg::ROW_OUT_W'(cmp_idx_q);
			was_inserted <= 1'b0;
			was_dropped  <= 1'b0;
			count_after  <= cnt_new;
			total_after  <= tot_new;
			rows_in_use  <= kect_pkg::ROWS_OUT_W'(occ_q);
			drop_count   <= drop_q;
		end
	end

endmodule

### src/keyed_event_counter_table.sv
// Channel   Handshake             Payload
// input     start / busy          ten key fields, work_amount
// result    done (one-cycle)      row_index .. drop_count
// config    cfg_valid / cfg_ready cfg_data (enable)
//
// In the back end the scan reads one stored key per cycle until it finds a match
// or runs past the occupied rows; on a hit the matched row's count and total are
// then read and rewritten.
// Reset clears control state and counters only; tables need no clearing pass.
// A two-word queue sits between front and back; busy is high while it is full.
// Results cannot be stalled by the receiver.
module keyed_event_counter_table #(
	parameter int TABLE_ROWS = kect_pkg::TABLE_ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           stage_id,
	input  logic [7:0]                           batch_capacity,
	input  logic [7:0]                           runnable_count,
	input  logic [7:0]                           effective_width,
	input  logic                                 contiguous_flag,
	input  logic [2:0]                           weight_kind,
	input  logic [2:0]                           operation_kind,
	input  logic [5:0]                           path_code,
	input  logic [5:0]                           leaf_code,
	input  logic [3:0]                           reason_code,
	input  logic [kect_pkg::AMT_W-1:0]           work_amount,
	output logic                                 done,
	output logic [kect_pkg::ROW_OUT_W-1:0]       row_index,
	output logic                                 was_inserted,
	output logic                                 was_dropped,
	output logic [kect_pkg::COUNT_W-1:0]         count_after,
	output logic [kect_pkg::AMT_W-1:0]           total_after,
	output logic [kect_pkg::ROWS_OUT_W-1:0]      rows_in_use,
	output logic [kect_pkg::COUNT_W-1:0]         drop_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data
);

	logic            enable_q;
	kect_pkg::item_t in_item;
	kect_pkg::item_t q_item;
	logic            q_vld;
	logic            q_take;

	assign cfg_ready = 1'b1;

	assign in_item.key = {stage_id, batch_capacity, runnable_count, effective_width,
		contiguous_flag, weight_kind, operation_kind, path_code, leaf_code, reason_code};
	assign in_item.amount = work_amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	kect_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.enable (enable_q),
		.start  (start),
		.item   (in_item),
		.busy   (busy),
		.q_vld  (q_vld),
		.q_item (q_item),
		.q_take (q_take)
	);

	kect_back #(
		.TABLE_ROWS (TABLE_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (q_vld),
		.q_item       (q_item),
		.q_take       (q_take),
		.done         (done),
		.row_index    (row_index),
		.was_inserted (was_inserted),
		.was_dropped  (was_dropped),
		.count_after  (count_after),
		.total_after  (total_after),
		.rows_in_use  (rows_in_use),
		.drop_count   (drop_count)
	);

`ifndef SYNTHESIS
	// result strobes from the back end never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes too close");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_dropped) |-> (row_index == '0) && (count_after == '0) &&
			(total_after == '0) && !was_inserted)
		else $error("dropped word carries row data");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_inserted) |-> (count_after == 1))
		else $error("new row count is not one");

	a_take_needs_vld: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_vld)
		else $error("queue popped while empty");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import kect_pkg::*;

	localparam int ROWS          = TABLE_ROWS_DEF;
	localparam int POOL_KEYS     = 96;
	localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 1) * (TABLE_ROWS_DEF + 4) + 16;
	localparam int PRINT_CAP     = 40;
	localparam logic [AMT_W-1:0] AMOUNT_MAX = '1;
	localparam logic [KEY_W-1:0] KEY_ONES   = '1;

	// key layout, most significant field first
	typedef struct packed {
		logic [2:0] stage_id;
		logic [7:0] batch_capacity;
		logic [7:0] runnable_count;
		logic [7:0] effective_width;
		logic       contiguous_flag;
		logic [2:0] weight_kind;
		logic [2:0] operation_kind;
		logic [5:0] path_code;
		logic [5:0] leaf_code;
		logic [3:0] reason_code;
	} key_fields_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0]  row_index;
		logic                  was_inserted;
		logic                  was_dropped;
		logic [COUNT_W-1:0]    count_after;
		logic [AMT_W-1:0]      total_after;
		logic [ROWS_OUT_W-1:0] rows_in_use;
		logic [COUNT_W-1:0]    drop_count;
	} tally_t;

	typedef struct {
		key_fields_t      key;
		logic [AMT_W-1:0] amount;
		bit               typed;
		tally_t           want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] stage_id = '0;
	logic [7:0] batch_capacity = '0;
	logic [7:0] runnable_count = '0;
	logic [7:0] effective_width = '0;
	logic contiguous_flag = 1'b0;
	logic [2:0] weight_kind = '0;
	logic [2:0] operation_kind = '0;
	logic [5:0] path_code = '0;
	logic [5:0] leaf_code = '0;
	logic [3:0] reason_code = '0;
	logic [AMT_W-1:0] work_amount = '0;
	logic done;
	logic [ROW_OUT_W-1:0] row_index;
	logic was_inserted;
	logic was_dropped;
	logic [COUNT_W-1:0] count_after;
	logic [AMT_W-1:0] total_after;
	logic [ROWS_OUT_W-1:0] rows_in_use;
	logic [COUNT_W-1:0] drop_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	keyed_event_counter_table dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the flow table
	key_fields_t        row_keys [ROWS];
	logic [COUNT_W-1:0] row_counts [ROWS];
	logic [AMT_W-1:0]   row_totals [ROWS];
	int                 rows_used = 0;
	logic [COUNT_W-1:0] drops_total = '0;
	logic               table_enabled = 1'b0;

	tally_t      pending_tallies [$];
	key_fields_t key_pool [POOL_KEYS];
	int          sender_idle_pct = 21;
	int          mismatch_count = 0;
	int          inserts_seen = 0;
	int          hits_seen = 0;
	int          drops_seen = 0;
	int          ignored_records = 0;

	directed_row_t directed_rows [14] = '{
		'{50'h0, 48'h0, 1'b1,
			{6'd0, 1'b1, 1'b0, 32'd1, 48'd0, 7'd1, 32'd0}},
		'{KEY_ONES, AMOUNT_MAX, 1'b1,
			{6'd1, 1'b1, 1'b0, 32'd1, AMOUNT_MAX, 7'd2, 32'd0}},
		'{KEY_ONES, 48'd1, 1'b1,
			{6'd1, 1'b0, 1'b0, 32'd2, AMOUNT_MAX, 7'd2, 32'd0}},
		'{50'h0, AMOUNT_MAX, 1'b1,
			{6'd0, 1'b0, 1'b0, 32'd2, AMOUNT_MAX, 7'd2, 32'd0}},
		'{50'h0, AMOUNT_MAX, 1'b1,
			{6'd0, 1'b0, 1'b0, 32'd3, AMOUNT_MAX, 7'd2, 32'd0}},
		'{50'h1, 48'd1, 1'b1,
			{6'd2, 1'b1, 1'b0, 32'd1, 48'd1, 7'd3, 32'd0}},
		'{50'h2_0000_0000_0000, 48'h8000_0000_0000, 1'b1,
			{6'd3, 1'b1, 1'b0, 32'd1, 48'h8000_0000_0000, 7'd4, 32'd0}},
		'{50'h1, 48'hFFFF_FFFF_FFFE, 1'b1,
			{6'd2, 1'b0, 1'b0, 32'd2, AMOUNT_MAX, 7'd4, 32'd0}},
		'{50'h1_5555_5555_5555, 48'h5555_5555_5555, 1'b0, '0},
		'{50'h2_AAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
		'{50'h1_5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
		'{50'h3_FFFF_FFFF_FFFE, 48'd0, 1'b0, '0},
		'{50'h1_FFFF_FFFF_FFFF, 48'd7, 1'b0, '0},
		'{KEY_ONES, 48'd0, 1'b1,
			{6'd1, 1'b0, 1'b0, 32'd3, AMOUNT_MAX, 7'd8, 32'd0}}
	};

	// linear lookup, append on miss, saturating count/total/drops
	function automatic tally_t tally_record(input key_fields_t key, input logic [AMT_W-1:0] amount);
		tally_t         res;
		int             hit_row;
		logic [AMT_W:0] sum;
		res = '0;
		hit_row = -1;
		for (int i = 0; i < rows_used; i++) begin
			if (hit_row < 0 && row_keys[i] == key)
				hit_row = i;
		end
		// a fresh row starts from zero and then takes the same update as a hit
		if (hit_row < 0 && rows_used < ROWS) begin
			hit_row = rows_used;
			row_keys[hit_row] = key;
			row_counts[hit_row] = '0;
			row_totals[hit_row] = '0;
			rows_used++;
			res.was_inserted = 1'b1;
		end
		if (hit_row >= 0) begin
			if (row_counts[hit_row] != '1)
				row_counts[hit_row] = row_counts[hit_row] + 1'b1;
			sum = {1'b0, row_totals[hit_row]} + {1'b0, amount};
			row_totals[hit_row] = sum[AMT_W] ? AMOUNT_MAX : sum[AMT_W-1:0];
			res.row_index = hit_row[ROW_OUT_W-1:0];
			res.count_after = row_counts[hit_row];
			res.total_after = row_totals[hit_row];
		end else begin
			if (drops_total != '1)
				drops_total = drops_total + 1'b1;
			res.was_dropped = 1'b1;
		end
		res.rows_in_use = rows_used[ROWS_OUT_W-1:0];
		res.drop_count = drops_total;
		return res;
	endfunction

	function automatic key_fields_t random_key();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[KEY_W-1:0];
	endfunction

	function automatic logic [AMT_W-1:0] random_amount();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		case ($urandom_range(15))
			0: return '0;
			1: return AMOUNT_MAX;
			2: return bits[AMT_W-1:0];
			default: return {16'd0, bits[31:0]};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
	endtask

	task automatic settle_results(input int linger);
		do @(posedge clk); while (pending_tallies.size() != 0);
		repeat (linger) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_enabled = value;
	endtask

	task automatic send_record(input key_fields_t key, input logic [AMT_W-1:0] amount,
			input bit typed, input tally_t want);
		tally_t predicted;
		int     gap;
		{stage_id, batch_capacity, runnable_count, effective_width, contiguous_flag,
			weight_kind, operation_kind, path_code, leaf_code, reason_code} <= key;
		work_amount <= amount;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (table_enabled) begin
			predicted = tally_record(key, amount);
			pending_tallies.push_back(typed ? want : predicted);
		end else begin
			ignored_records++;
		end
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			// mostly short gaps, sometimes long enough to let the scan finish
			gap = ($urandom_range(7) == 0) ? $urandom_range(70, 10) : $urandom_range(4, 1);
			repeat (gap) @(posedge clk);
		end
	endtask

	// enable off, some ignored words, enable back on
	task automatic disabled_burst(input int n_words);
		settle_results(SETTLE_CYCLES);
		write_enable(1'b0);
		for (int i = 0; i < n_words; i++)
			send_record(random_key(), random_amount(), 1'b0, '0);
		start <= 1'b0;
		settle_results(SETTLE_CYCLES);
		write_enable(1'b1);
	endtask

	task automatic random_phase(input int n_words, input int pool_span, input int idle_pct);
		key_fields_t key;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(19) == 0)
				key = random_key();
			else
				key = key_pool[$urandom_range(pool_span - 1)];
			send_record(key, random_amount(), 1'b0, '0);
			if (i % 150 == 149) begin
				start <= 1'b0;
				settle_results(0);
			end
		end
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		tally_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_tallies.size() == 0) begin
				report_mismatch("result with nothing pending", row_index, 0);
			end else begin
				want = pending_tallies.pop_front();
				if (want.was_inserted)
					inserts_seen++;
				else if (want.was_dropped)
					drops_seen++;
				else
					hits_seen++;
				if (row_index !== want.row_index)
					report_mismatch("row_index", row_index, want.row_index);
				if (was_inserted !== want.was_inserted)
					report_mismatch("was_inserted", was_inserted, want.was_inserted);
				if (was_dropped !== want.was_dropped)
					report_mismatch("was_dropped", was_dropped, want.was_dropped);
				if (count_after !== want.count_after)
					report_mismatch("count_after", count_after, want.count_after);
				if (total_after !== want.total_after)
					report_mismatch("total_after", total_after, want.total_after);
				if (rows_in_use !== want.rows_in_use)
					report_mismatch("rows_in_use", rows_in_use, want.rows_in_use);
				if (drop_count !== want.drop_count)
					report_mismatch("drop_count", drop_count, want.drop_count);
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] one_bit;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// records while disabled must leave no trace
		write_enable(1'b0);
		send_record(KEY_ONES, AMOUNT_MAX, 1'b0, '0);
		send_record('0, '0, 1'b0, '0);
		send_record(random_key(), random_amount(), 1'b0, '0);
		start <= 1'b0;
		settle_results(SETTLE_CYCLES);
		write_enable(1'b1);

		foreach (directed_rows[i])
			send_record(directed_rows[i].key, directed_rows[i].amount,
				directed_rows[i].typed, directed_rows[i].want);

		// every eighth pool key is a one-bit neighbor of the one before it
		for (int i = 0; i < POOL_KEYS; i++) begin
			if (i % 8 == 7) begin
				one_bit = '0;
				one_bit[$urandom_range(KEY_W - 1)] = 1'b1;
				key_pool[i] = key_pool[i-1] ^ one_bit;
			end else begin
				key_pool[i] = random_key();
			end
		end

		// small pool first so rows fill gradually, then misses past a full table
		random_phase(440, 40, 21);
		disabled_burst(25);
		random_phase(440, POOL_KEYS, 54);
		disabled_burst(25);
		random_phase(440, POOL_KEYS, 0);

		settle_results(SETTLE_CYCLES);
		$display("covered %0d handled records: %0d new rows, %0d hits, %0d drops",
			inserts_seen + hits_seen + drops_seen, inserts_seen, hits_seen, drops_seen);
		$display("plus %0d records ignored while disabled, table ended with %0d rows",
			ignored_records, rows_used);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results still pending", pending_tallies.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
src/kect_pkg.sv
src/kect_front.sv
src/kect_back.sv
src/keyed_event_counter_table.sv
dv/tb_top.sv
